// ----- hw/rtl/prc_pkg.sv -----
// ----------------------------------------------------------------------------
// prc_pkg
// Shared constants and register codes of the rectangle polyline clipper.
// ----------------------------------------------------------------------------
package prc_pkg;

  // Width of the coordinate, configuration and result fields on the ports
  localparam int unsigned FieldBits    = 32;
  // Default coordinate width used inside the core
  localparam int unsigned CoordBitsDef = 32;
  // Width of the configuration register index
  localparam int unsigned CfgIdxBits   = 2;

  typedef enum logic [CfgIdxBits-1:0] {
    REG_X_MIN = 2'd0,
    REG_X_MAX = 2'd1,
    REG_Y_MIN = 2'd2,
    REG_Y_MAX = 2'd3
  } cfg_reg_e;

endpackage

// ----- hw/rtl/polyline_rectangle_clipper_core.sv -----
// ----------------------------------------------------------------------------
// polyline_rectangle_clipper_core
// Streamed clipping of polylines and rings against a rectangle; the x_min,
// x_max, y_min, y_max passes run in turn on a shared stage unit and divider.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                | payload
//  in      | input     | in_valid_i / in_stall_o  | point_x, point_y, first/last
//  out     | output    | out_valid_o / out_stall_i| out_x, out_y, point_valid,
//          |           |                          | line_end, run_last
//  cfg     | input     | cfg_we_i                 | cfg_index_i, cfg_wdata_i
//
// A point that only enters the front buffer needs no edge pass; otherwise the
// sequencer runs the edge passes in turn as long as each hands a point on,
// and every edge crossing adds two multiplies on the shared multiplier, one add,
// the divider (one quotient bit per cycle) and a step to pass the new point
// on; an inward crossing also frees the inside point held behind it.
// in_stall_o is high from the accepted transfer until the last result is
// parked in the output register. Output stalls hold the sequencer only when a
// result must be handed on. Reset clears all control state; no clearing pass.
module polyline_rectangle_clipper_core
  import prc_pkg::*;
#(
  parameter int unsigned COORD_BITS = CoordBitsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [FieldBits-1:0]  point_x_i,
  input  logic [FieldBits-1:0]  point_y_i,
  input  logic                  first_point_i,
  input  logic                  last_point_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [FieldBits-1:0]  out_x_o,
  output logic [FieldBits-1:0]  out_y_o,
  output logic                  point_valid_o,
  output logic                  line_end_o,
  output logic                  run_last_o,
  input  logic                  cfg_we_i,
  input  logic [CfgIdxBits-1:0] cfg_index_i,
  input  logic [FieldBits-1:0]  cfg_wdata_i
);

  localparam int unsigned W    = COORD_BITS;
  localparam int unsigned PW   = 2 * W;
  localparam int unsigned CntW = $clog2(W);

  typedef enum logic [3:0] {
    S_IDLE, S_FRONT, S_NEXT, S_STAGE, S_MUL0, S_MUL1, S_ADD, S_DIV, S_XOUT,
    S_TAIL, S_TFIN, S_END
  } state_e;

  state_e state_q;

  logic [W-1:0]    x_min_q, x_max_q, y_min_q, y_max_q;
  logic [PW-1:0]   pin_q;
  logic            last_q;
  logic [1:0]      fc_q;
  logic [PW-1:0]   front_q [2];
  logic            fi_q;
  logic [PW-1:0]   line_first_q;
  logic [PW-1:0]   stg_prev_q  [4];
  logic [PW-1:0]   stg_first_q [4];
  logic [PW-1:0]   stg_last_q  [4];
  logic [3:0]      stg_prev_in_q, stg_has_q, stg_start_q;
  logic [3:0]      pend_v_q;
  logic [PW-1:0]   pend_pt_q [4];
  logic [PW-1:0]   tail_q [2];
  logic [1:0]      tc_q;
  logic [PW-1:0]   cur_pt_q;
  logic [2:0]      tgt_q;
  logic            feeding_q;
  logic [1:0]      src_q;
  logic [2:0]      close_k_q;
  logic [W-1:0]    t_q, d_q, a_q, b_q, e_q;
  logic            kx_q;
  logic [PW-1:0]   acc_q, prod_q, div_q;
  logic [CntW-1:0] cnt_q;

  logic            res_v_q, res_pv_q, res_end_q;
  logic [PW-1:0]   res_pt_q;
  logic            out_v_q, out_pv_q, out_end_q, out_last_q;
  logic [PW-1:0]   out_pt_q;

  // --------------------------------------------------------------------------
  // Combinational helpers
  // --------------------------------------------------------------------------
  logic [1:0]    k;
  logic [W-1:0]  px, py;
  logic          inn;
  logic [W-1:0]  u_cur, u_prev, v_cur, v_prev, edge_v;
  logic [W-1:0]  t_c, d_c;
  logic [W-1:0]  mul_x, mul_y;
  logic [PW-1:0] mul_p;
  logic [W:0]    dv_tmp, dv_hi;
  logic          dv_ge;
  logic          pend_any;
  logic [1:0]    pend_k;
  logic [PW-1:0] src_pt;
  logic [1:0]    ck;
  logic          close_hit;
  logic [PW-1:0] x_pt;
  logic          out_free, emit_req, emit_ok, flush_req;
  logic          res_take, out_load;
  logic [PW-1:0] em_pt;
  logic          em_pv, em_end;
  logic          in_acc;
  logic [1:0]    fc_eff;
  logic [PW-1:0] p_in;

  assign k  = tgt_q[1:0];
  assign px = cur_pt_q[PW-1:W];
  assign py = cur_pt_q[W-1:0];

  always_comb begin
    case (k)
      2'd0:    inn = (px >= x_min_q);
      2'd1:    inn = (px <= x_max_q);
      2'd2:    inn = (py >= y_min_q);
      default: inn = (py <= y_max_q);
    endcase
  end

  always_comb begin
    if (!k[1]) begin
      u_cur  = px;
      u_prev = stg_prev_q[k][PW-1:W];
      v_cur  = py;
      v_prev = stg_prev_q[k][W-1:0];
      edge_v = k[0] ? x_max_q : x_min_q;
    end else begin
      u_cur  = py;
      u_prev = stg_prev_q[k][W-1:0];
      v_cur  = px;
      v_prev = stg_prev_q[k][PW-1:W];
      edge_v = k[0] ? y_max_q : y_min_q;
    end
    // t and d share a sign; take magnitudes
    if (u_cur >= u_prev) begin
      t_c = u_cur - edge_v;
      d_c = u_cur - u_prev;
    end else begin
      t_c = edge_v - u_cur;
      d_c = u_prev - u_cur;
    end
  end

  // shared multiplier: t*a first, (d-t)*b next
  assign mul_x = (state_q == S_MUL0) ? t_q : (d_q - t_q);
  assign mul_y = (state_q == S_MUL0) ? a_q : b_q;
  assign mul_p = PW'(mul_x) * PW'(mul_y);

  // restoring divider step; numerator high half stays below d
  assign dv_tmp = {div_q[PW-1:W], div_q[W-1]};
  assign dv_ge  = (dv_tmp >= {1'b0, d_q});
  assign dv_hi  = dv_ge ? (dv_tmp - {1'b0, d_q}) : dv_tmp;

  assign x_pt = kx_q ? {e_q, div_q[W-1:0]} : {div_q[W-1:0], e_q};

  always_comb begin
    pend_any = |pend_v_q;
    pend_k   = 2'd0;
    for (int i = 0; i < 4; i++) begin
      if (pend_v_q[i]) pend_k = 2'(i);
    end
  end

  always_comb begin
    case (src_q)
      2'd0:    src_pt = front_q[0];
      2'd1:    src_pt = front_q[1];
      default: src_pt = pin_q;
    endcase
  end

  assign ck        = close_k_q[1:0];
  assign close_hit = (line_first_q == pin_q) && stg_has_q[ck] &&
                     (stg_first_q[ck] != stg_last_q[ck]);

  assign out_free = !out_v_q || !out_stall_i;
  assign emit_ok  = !res_v_q || out_free;

  always_comb begin
    emit_req = 1'b0;
    em_pt    = '0;
    em_pv    = 1'b0;
    em_end   = 1'b0;
    case (state_q)
      S_FRONT: begin
        emit_req = 1'b1;
        em_pt    = front_q[fi_q];
        em_pv    = 1'b1;
        em_end   = fi_q || (fc_q == 2'd1);
      end
      S_TAIL: begin
        if (tc_q[1]) begin
          emit_req = 1'b1;
          em_pt    = tail_q[0];
          em_pv    = 1'b1;
        end
      end
      S_TFIN: begin
        emit_req = 1'b1;
        em_end   = 1'b1;
        if (tc_q == 2'd2) begin
          if (tail_q[0] != tail_q[1]) begin
            em_pt  = tail_q[0];
            em_pv  = 1'b1;
            em_end = 1'b0;
          end
        end else if (tc_q != 2'd0) begin
          em_pt = tail_q[0];
          em_pv = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign flush_req = (state_q == S_END) && res_v_q;
  assign res_take  = emit_req && emit_ok;
  assign out_load  = res_v_q && (res_take || (flush_req && out_free));

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && (state_q == S_IDLE);
  assign fc_eff     = first_point_i ? 2'd0 : fc_q;
  assign p_in       = {point_x_i[W-1:0], point_y_i[W-1:0]};

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      x_min_q       <= '0;
      x_max_q       <= '1;
      y_min_q       <= '0;
      y_max_q       <= '1;
      fc_q          <= '0;
      tc_q          <= '0;
      stg_prev_in_q <= '0;
      stg_has_q     <= '0;
      stg_start_q   <= '0;
      pend_v_q      <= '0;
      feeding_q     <= 1'b0;
      close_k_q     <= '0;
      last_q        <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          REG_X_MIN: x_min_q <= cfg_wdata_i[W-1:0];
          REG_X_MAX: x_max_q <= cfg_wdata_i[W-1:0];
          REG_Y_MIN: y_min_q <= cfg_wdata_i[W-1:0];
          REG_Y_MAX: y_max_q <= cfg_wdata_i[W-1:0];
          default: ;
        endcase
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            pin_q  <= p_in;
            last_q <= last_point_i;
            if (fc_eff == 2'd0) begin
              line_first_q  <= p_in;
              stg_start_q   <= '0;
              stg_has_q     <= '0;
              stg_prev_in_q <= '0;
              tc_q          <= '0;
            end
            if (!fc_eff[1]) begin
              front_q[fc_eff[0]] <= p_in;
              fc_q               <= fc_eff + 2'd1;
              fi_q               <= 1'b0;
              state_q            <= last_point_i ? S_FRONT : S_END;
            end else begin
              feeding_q <= 1'b1;
              src_q     <= (fc_eff == 2'd2) ? 2'd0 : 2'd2;
              close_k_q <= '0;
              fc_q      <= last_point_i ? 2'd0 : 2'd3;
              state_q   <= S_NEXT;
            end
          end
        end

        S_FRONT: begin
          if (emit_ok) begin
            if (fi_q || (fc_q == 2'd1)) begin
              fc_q    <= '0;
              state_q <= S_END;
            end else begin
              fi_q <= 1'b1;
            end
          end
        end

        S_NEXT: begin
          if (pend_any) begin
            // inside point held behind a crossing leaves its pass now
            pend_v_q[pend_k] <= 1'b0;
            cur_pt_q         <= pend_pt_q[pend_k];
            tgt_q            <= {1'b0, pend_k} + 3'd1;
            if (!stg_has_q[pend_k]) begin
              stg_first_q[pend_k] <= pend_pt_q[pend_k];
              stg_has_q[pend_k]   <= 1'b1;
            end
            stg_last_q[pend_k] <= pend_pt_q[pend_k];
            state_q <= (pend_k == 2'd3) ? S_TAIL : S_STAGE;
          end else if (feeding_q) begin
            cur_pt_q <= src_pt;
            tgt_q    <= '0;
            src_q    <= src_q + 2'd1;
            if (src_q == 2'd2) feeding_q <= 1'b0;
            state_q  <= S_STAGE;
          end else if (last_q && !close_k_q[2]) begin
            // ring closure, one pass at a time
            close_k_q <= close_k_q + 3'd1;
            if (close_hit) begin
              cur_pt_q        <= stg_first_q[ck];
              tgt_q           <= {1'b0, ck} + 3'd1;
              stg_last_q[ck]  <= stg_first_q[ck];
              state_q         <= (ck == 2'd3) ? S_TAIL : S_STAGE;
            end
          end else if (last_q) begin
            state_q <= S_TFIN;
          end else begin
            state_q <= S_END;
          end
        end

        S_STAGE: begin
          stg_start_q[k]   <= 1'b1;
          stg_prev_q[k]    <= cur_pt_q;
          stg_prev_in_q[k] <= inn;
          if (stg_start_q[k] && (stg_prev_in_q[k] != inn)) begin
            t_q  <= t_c;
            d_q  <= d_c;
            a_q  <= v_prev;
            b_q  <= v_cur;
            e_q  <= edge_v;
            kx_q <= !k[1];
            if (inn) begin
              pend_v_q[k]  <= 1'b1;
              pend_pt_q[k] <= cur_pt_q;
            end
            state_q <= S_MUL0;
          end else if (inn) begin
            if (!stg_has_q[k]) begin
              stg_first_q[k] <= cur_pt_q;
              stg_has_q[k]   <= 1'b1;
            end
            stg_last_q[k] <= cur_pt_q;
            tgt_q         <= tgt_q + 3'd1;
            state_q       <= (k == 2'd3) ? S_TAIL : S_STAGE;
          end else begin
            state_q <= S_NEXT;
          end
        end

        S_MUL0: begin
          prod_q  <= mul_p;
          state_q <= S_MUL1;
        end

        S_MUL1: begin
          acc_q   <= prod_q;
          prod_q  <= mul_p;
          state_q <= S_ADD;
        end

        S_ADD: begin
          div_q   <= acc_q + prod_q;
          cnt_q   <= '0;
          state_q <= S_DIV;
        end

        S_DIV: begin
          div_q <= {dv_hi[W-1:0], div_q[W-2:0], dv_ge};
          cnt_q <= cnt_q + CntW'(1);
          if (cnt_q == CntW'(W - 1)) state_q <= S_XOUT;
        end

        S_XOUT: begin
          if (!stg_has_q[k]) begin
            stg_first_q[k] <= x_pt;
            stg_has_q[k]   <= 1'b1;
          end
          stg_last_q[k] <= x_pt;
          cur_pt_q      <= x_pt;
          tgt_q         <= tgt_q + 3'd1;
          state_q       <= (k == 2'd3) ? S_TAIL : S_STAGE;
        end

        S_TAIL: begin
          case (tc_q)
            2'd0: begin
              tail_q[0] <= cur_pt_q;
              tc_q      <= 2'd1;
              state_q   <= S_NEXT;
            end
            2'd1: begin
              tail_q[1] <= cur_pt_q;
              tc_q      <= 2'd2;
              state_q   <= S_NEXT;
            end
            2'd2: begin
              // first held point goes out; then handled as streaming
              if (emit_ok) begin
                tail_q[0] <= tail_q[1];
                tc_q      <= 2'd3;
              end
            end
            default: begin
              if (emit_ok) begin
                tail_q[0] <= cur_pt_q;
                state_q   <= S_NEXT;
              end
            end
          endcase
        end

        S_TFIN: begin
          if (emit_ok) begin
            if ((tc_q == 2'd2) && (tail_q[0] != tail_q[1])) begin
              tail_q[0] <= tail_q[1];
              tc_q      <= 2'd1;
            end else begin
              tc_q    <= '0;
              state_q <= S_END;
            end
          end
        end

        S_END: begin
          if (!res_v_q || out_free) state_q <= S_IDLE;
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Result hold-back (to mark the last one of an item) and output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_v_q <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (res_take) begin
        res_v_q   <= 1'b1;
        res_pt_q  <= em_pt;
        res_pv_q  <= em_pv;
        res_end_q <= em_end;
      end else if (flush_req && out_free) begin
        res_v_q <= 1'b0;
      end

      if (out_load) begin
        out_v_q    <= 1'b1;
        out_pt_q   <= res_pt_q;
        out_pv_q   <= res_pv_q;
        out_end_q  <= res_end_q;
        out_last_q <= !res_take;
      end else if (!out_stall_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  assign out_valid_o   = out_v_q;
  assign out_x_o       = FieldBits'(out_pt_q[PW-1:W]);
  assign out_y_o       = FieldBits'(out_pt_q[W-1:0]);
  assign point_valid_o = out_pv_q;
  assign line_end_o    = out_end_q;
  assign run_last_o    = out_last_q;

endmodule

// ----- hw/rtl/prc_checker.sv -----
// ----------------------------------------------------------------------------
// prc_checker
// Port-level checks of the clipper result stream, bound to the core.
// ----------------------------------------------------------------------------
module prc_checker
  import prc_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input logic [FieldBits-1:0] out_x_o,
  input logic [FieldBits-1:0] out_y_o,
  input logic                 point_valid_o,
  input logic                 line_end_o,
  input logic                 run_last_o
);

  // a stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // a bare end marker carries zero coordinates
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !point_valid_o |-> (out_x_o == '0) && (out_y_o == '0))
    else $error("bare marker with coordinates");

  // a result without a point only ever closes a line
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !point_valid_o |-> line_end_o)
    else $error("bare marker not at line end");

  // the end of a line is always the last result of its transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && line_end_o |-> run_last_o)
    else $error("line end not last of transfer");

endmodule

bind polyline_rectangle_clipper_core prc_checker u_prc_checker (.*);

// ----- verif/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the rectangle polyline clipper: directed lines and
// rings, then random lines under several clip rectangles, with random idle
// cycles on both channels, checked point by point against a predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb
  import prc_pkg::*;
();

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    bit          pv;
    bit          le;
    bit          rl;
  } clip_pt_t;

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    bit          fst;
    bit          lst;
    bit          known;
    logic [31:0] kx;
    logic [31:0] ky;
    bit          kv;
  } vec_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [31:0] point_x_i = '0;
  logic [31:0] point_y_i = '0;
  logic first_point_i = 1'b0;
  logic last_point_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [31:0] out_x_o, out_y_o;
  logic point_valid_o, line_end_o, run_last_o;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxBits-1:0] cfg_index_i = REG_X_MIN;
  logic [31:0] cfg_wdata_i = '0;

  always #10 clk_i = ~clk_i;

  polyline_rectangle_clipper_core i_dut (.*);

  // predictor state
  logic [31:0] rect_lo_x, rect_hi_x, rect_lo_y, rect_hi_y;
  logic [63:0] head_pts[2];
  int          head_cnt;
  logic [63:0] line_start;
  logic [63:0] edge_prev[4];
  bit          edge_prev_in[4];
  logic [63:0] edge_first[4];
  logic [63:0] edge_last[4];
  bit          edge_has[4];
  bit          edge_run[4];
  logic [63:0] tail_pts[2];
  int          tail_cnt;

  clip_pt_t step_pts[$];
  clip_pt_t pending_pts[$];
  int errors = 0;
  bit calm = 1'b0;

  function automatic void emit_pt(logic [63:0] p, bit v, bit e);
    clip_pt_t r;
    r.x = v ? p[63:32] : '0;
    r.y = v ? p[31:0] : '0;
    r.pv = v;
    r.le = e;
    r.rl = 1'b0;
    step_pts.insert(step_pts.size(), r);
  endfunction

  function automatic void tail_add(logic [63:0] p);
    if (tail_cnt < 2) begin
      tail_pts[tail_cnt] = p;
      tail_cnt++;
    end else if (tail_cnt == 2) begin
      emit_pt(tail_pts[0], 1, 0);
      emit_pt(tail_pts[1], 1, 0);
      tail_pts[0] = p;
      tail_cnt = 3;
    end else begin
      emit_pt(tail_pts[0], 1, 0);
      tail_pts[0] = p;
    end
  endfunction

  function automatic void tail_close();
    if (tail_cnt == 0) begin
      emit_pt('0, 0, 1);
    end else if (tail_cnt == 2) begin
      if (tail_pts[0] == tail_pts[1]) begin
        emit_pt('0, 0, 1);
      end else begin
        emit_pt(tail_pts[0], 1, 0);
        emit_pt(tail_pts[1], 1, 1);
      end
    end else begin
      emit_pt(tail_pts[0], 1, 1);
    end
    tail_cnt = 0;
  endfunction

  function automatic bit on_side(int k, logic [63:0] p);
    case (k)
      0: return p[63:32] >= rect_lo_x;
      1: return p[63:32] <= rect_hi_x;
      2: return p[31:0] >= rect_lo_y;
      default: return p[31:0] <= rect_hi_y;
    endcase
  endfunction

  // exact floor of (t*a + (d-t)*b) / d, t and d sharing a sign
  function automatic logic [31:0] lerp(longint t, longint d, logic [31:0] a,
                                       logic [31:0] b);
    logic [63:0] ut, ud, num;
    if (d < 0) begin
      t = -t;
      d = -d;
    end
    if (d == 0) return b;
    if (t < 0) t = 0;
    if (t > d) t = d;
    ut = t;
    ud = d;
    num = ut * {32'd0, a} + (ud - ut) * {32'd0, b};
    return 32'(num / ud);
  endfunction

  function automatic logic [63:0] edge_cut(int k, logic [63:0] pv, logic [63:0] cu);
    logic [31:0] e;
    longint t, d;
    if (k < 2) begin
      e = (k == 0) ? rect_lo_x : rect_hi_x;
      t = longint'(cu[63:32]) - longint'(e);
      d = longint'(cu[63:32]) - longint'(pv[63:32]);
      return {e, lerp(t, d, pv[31:0], cu[31:0])};
    end
    e = (k == 2) ? rect_lo_y : rect_hi_y;
    t = longint'(cu[31:0]) - longint'(e);
    d = longint'(cu[31:0]) - longint'(pv[31:0]);
    return {lerp(t, d, pv[63:32], cu[63:32]), e};
  endfunction

  function automatic void edge_emit(int k, logic [63:0] q);
    if (!edge_has[k]) begin
      edge_first[k] = q;
      edge_has[k] = 1'b1;
    end
    edge_last[k] = q;
    edge_feed(k + 1, q);
  endfunction

  function automatic void edge_feed(int k, logic [63:0] p);
    bit ins;
    if (k >= 4) begin
      tail_add(p);
      return;
    end
    ins = on_side(k, p);
    if (edge_run[k] && edge_prev_in[k] != ins) edge_emit(k, edge_cut(k, edge_prev[k], p));
    if (ins) edge_emit(k, p);
    edge_run[k] = 1'b1;
    edge_prev[k] = p;
    edge_prev_in[k] = ins;
  endfunction

  function automatic void clip_point(logic [31:0] x, logic [31:0] y, bit fst, bit lst);
    logic [63:0] p;
    p = {x, y};
    step_pts.delete();
    if (fst) head_cnt = 0;
    if (head_cnt == 0) begin
      line_start = p;
      for (int k = 0; k < 4; k++) begin
        edge_run[k] = 0;
        edge_has[k] = 0;
        edge_prev_in[k] = 0;
      end
      tail_cnt = 0;
    end
    if (head_cnt < 2) begin
      head_pts[head_cnt] = p;
      head_cnt++;
      if (lst) begin
        for (int i = 0; i < head_cnt; i++) emit_pt(head_pts[i], 1, i + 1 == head_cnt);
        head_cnt = 0;
      end
    end else begin
      if (head_cnt == 2) begin
        edge_feed(0, head_pts[0]);
        edge_feed(0, head_pts[1]);
        head_cnt = 3;
      end
      edge_feed(0, p);
      if (lst) begin
        // a ring is closed again after every edge pass
        for (int k = 0; k < 4; k++)
          if (line_start == p && edge_has[k] && edge_first[k] != edge_last[k])
            edge_emit(k, edge_first[k]);
        tail_close();
        head_cnt = 0;
      end
    end
    if (step_pts.size() > 0) step_pts[step_pts.size() - 1].rl = 1'b1;
  endfunction

  task automatic write_reg(cfg_reg_e idx, logic [31:0] val);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_index_i = idx;
    cfg_wdata_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      REG_X_MIN: rect_lo_x = val;
      REG_X_MAX: rect_hi_x = val;
      REG_Y_MIN: rect_lo_y = val;
      default:   rect_hi_y = val;
    endcase
  endtask

  task automatic drain();
    while (pending_pts.size() > 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  task automatic set_rect(logic [31:0] x0, logic [31:0] x1, logic [31:0] y0,
                          logic [31:0] y1);
    drain();
    write_reg(REG_X_MIN, x0);
    write_reg(REG_X_MAX, x1);
    write_reg(REG_Y_MIN, y0);
    write_reg(REG_Y_MAX, y1);
  endtask

  task automatic send_point(vec_t v);
    clip_pt_t got;
    @(negedge clk_i);
    while (!calm && $urandom_range(99) < 8) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    point_x_i = v.x;
    point_y_i = v.y;
    first_point_i = v.fst;
    last_point_i = v.lst;
    do @(posedge clk_i); while (in_stall_o);
    clip_point(v.x, v.y, v.fst, v.lst);
    got = '{'0, '0, 0, 0, 0};
    if (step_pts.size() > 0) got = step_pts[0];
    if (v.known && (step_pts.size() != 1 || got.x != v.kx ||
                    got.y != v.ky || got.pv != v.kv)) begin
      $display("%0t: predictor disagrees on fixed row exp %h,%h,%b act %h,%h,%b (%0d results)",
               $time, v.kx, v.ky, v.kv, got.x, got.y, got.pv, step_pts.size());
      errors++;
    end
    foreach (step_pts[i]) pending_pts.insert(pending_pts.size(), step_pts[i]);
  endtask

  task automatic idle_input();
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  function automatic vec_t mkv(logic [31:0] x, logic [31:0] y, bit f, bit l);
    vec_t v;
    v = '{x, y, f, l, 0, 0, 0, 0};
    return v;
  endfunction

  function automatic vec_t mkk(logic [31:0] x, logic [31:0] y, bit f, bit l,
                               logic [31:0] kx, logic [31:0] ky, bit kv);
    vec_t v;
    v = '{x, y, f, l, 1, kx, ky, kv};
    return v;
  endfunction

  function automatic logic [31:0] rnd_coord(logic [31:0] lo, logic [31:0] hi);
    int r;
    r = $urandom_range(99);
    if (r < 8) return $urandom();
    if (r < 12) return (r < 10) ? 32'd0 : 32'hFFFF_FFFF;
    if (hi >= lo && hi - lo < 32'h4000_0000) begin
      if (lo > 600 && hi < 32'hFFFF_F000) return $urandom_range(hi + 600, lo - 600);
      return $urandom_range(hi, lo);
    end
    return $urandom();
  endfunction

  task automatic rand_line(int npts, bit ring);
    vec_t v;
    logic [31:0] fx, fy;
    for (int i = 0; i < npts; i++) begin
      v = mkv(rnd_coord(rect_lo_x, rect_hi_x), rnd_coord(rect_lo_y, rect_hi_y),
              i == 0, i == npts - 1);
      if (i == 0) begin
        fx = v.x;
        fy = v.y;
      end
      if (ring && i == npts - 1) begin
        v.x = fx;
        v.y = fy;
      end
      send_point(v);
    end
  endtask

  vec_t table_rows[$];

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_pts.size() == 0) begin
        $display("%0t: unexpected transfer exp none act %h,%h,%b,%b,%b", $time,
                 out_x_o, out_y_o, point_valid_o, line_end_o, run_last_o);
        errors++;
      end else begin
        clip_pt_t e;
        e = pending_pts.pop_front();
        if (e.x !== out_x_o || e.y !== out_y_o || e.pv !== point_valid_o ||
            e.le !== line_end_o || e.rl !== run_last_o) begin
          $display("%0t: result mismatch exp %h,%h,%b,%b,%b act %h,%h,%b,%b,%b", $time,
                   e.x, e.y, e.pv, e.le, e.rl,
                   out_x_o, out_y_o, point_valid_o, line_end_o, run_last_o);
          errors++;
        end
      end
    end
  end

  always @(negedge clk_i) out_stall_i <= !calm && ($urandom_range(99) < 8);

  initial begin
    #20ms;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    rect_lo_x = '0;
    rect_hi_x = '1;
    rect_lo_y = '0;
    rect_hi_y = '1;
    head_cnt = 0;
    tail_cnt = 0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset rectangle covers everything
    send_point(mkk(32'd0, 32'd0, 1, 1, 32'd0, 32'd0, 1));
    send_point(mkk(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1));
    send_point(mkv(32'd5, 32'd6, 1, 0));
    send_point(mkv(32'd7, 32'd8, 0, 1));
    idle_input();

    set_rect(32'd100, 32'd200, 32'd100, 32'd200);
    // diamond ring crossing every edge of the rectangle
    table_rows = '{mkv(50, 150, 1, 0), mkv(150, 50, 0, 0), mkv(250, 150, 0, 0),
                   mkv(150, 250, 0, 0), mkv(50, 150, 0, 1),
                   // open line fully inside
                   mkv(120, 120, 1, 0), mkv(180, 130, 0, 0), mkv(150, 190, 0, 1),
                   // fully outside: bare end marker
                   mkv(10, 10, 1, 0), mkv(20, 10, 0, 0), mkv(30, 40, 0, 1),
                   // no first mark while idle starts a line
                   mkv(150, 150, 0, 0), mkv(160, 160, 0, 0), mkv(300, 300, 0, 1),
                   // first mark mid-line drops the open line
                   mkv(110, 110, 1, 0), mkv(120, 120, 0, 0), mkv(130, 130, 0, 0),
                   mkv(140, 150, 1, 0), mkv(190, 150, 0, 0), mkv(150, 120, 0, 1),
                   // clipped to two equal points: dropped
                   mkv(200, 150, 1, 0), mkv(250, 150, 0, 0), mkv(250, 160, 0, 1)};
    foreach (table_rows[i]) send_point(table_rows[i]);
    idle_input();

    // degenerate rectangle cuts everything
    set_rect(32'd300, 32'd100, 32'd0, 32'hFFFF_FFFF);
    send_point(mkv(150, 150, 1, 0));
    send_point(mkv(400, 150, 0, 0));
    send_point(mkv(50, 20, 0, 1));
    idle_input();

    for (int ph = 0; ph < 6; ph++) begin
      logic [31:0] a, b, c, d;
      case (ph)
        0: begin a = 0; b = 32'hFFFF_FFFF; c = 0; d = 32'hFFFF_FFFF; end
        1: begin a = 32'hFFFF_FFFF; b = 32'hFFFF_FFFF; c = 0; d = 32'hFFFF_FFFF; end
        2: begin a = $urandom(); b = $urandom(); c = $urandom(); d = $urandom(); end
        default: begin
          a = $urandom_range(3000, 700);
          b = a + $urandom_range(2000);
          c = $urandom_range(3000, 700);
          d = c + $urandom_range(2000);
        end
      endcase
      set_rect(a, b, c, d);
      calm = (ph == 4);
      for (int n = 0; n < 3; n++) begin
        int r, np;
        r = $urandom_range(99);
        np = $urandom_range(7, 3);
        if (r < 80) begin
          rand_line(np, r < 45);
        end else if (r < 90) begin
          // short line, then a point that opens a line without a first mark
          rand_line($urandom_range(2, 1), 0);
          send_point(mkv($urandom(), $urandom(), 0, 0));
        end else begin
          np = $urandom_range(4, 1);
          for (int i = 0; i < np; i++)
            send_point(mkv($urandom(), $urandom(), $urandom_range(1), $urandom_range(1)));
        end
      end
      // close any line left open
      send_point(mkv($urandom(), $urandom(), 0, 1));
      idle_input();
      calm = 1'b0;
    end

    drain();
    if (errors == 0 && pending_pts.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
